// File: rtl/fixed_partition_fit_allocator_macros.svh
// Assertion macros shared by the allocator modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_MACROS_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FPFA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FPFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/fpfa_pkg.sv
// Shared types and constants of the fixed partition fit allocator.
// Used by the controller, the datapath and the top level.
package fpfa_pkg;

   localparam int MAX_PARTS = 16;
   localparam int IDX_W     = $clog2(MAX_PARTS);
   localparam int SIZE_W    = 16;
   localparam int CNT_W     = 5;
   localparam int PID_W     = 16;
   localparam int FUNC_W    = 2;
   localparam int PIDX_W    = 4;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_FIRST = 2'd1,
      FUNC_WORST = 2'd2,
      FUNC_BEST  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic scan_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scan_skip;
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

// File: rtl/fpfa_datapath.sv
// Datapath of the allocator: partition table, scan candidate, count and result register.
// Depends on fpfa_pkg and the assertion macro header.
`include "fixed_partition_fit_allocator_macros.svh"

module fpfa_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  fpfa_pkg::cmd_type           cmd,
   output fpfa_pkg::status_type        status,
   input  logic [fpfa_pkg::FUNC_W-1:0] req_func,
   input  logic [fpfa_pkg::PIDX_W-1:0] req_part_index,
   input  logic [fpfa_pkg::SIZE_W-1:0] req_part_size,
   input  logic [fpfa_pkg::SIZE_W-1:0] req_request_size,
   input  logic [fpfa_pkg::PID_W-1:0]  req_process_id,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_granted,
   output logic [fpfa_pkg::CNT_W-1:0]  rsp_partition_number,
   output logic [fpfa_pkg::PID_W-1:0]  rsp_process_id_out,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [fpfa_pkg::CNT_W-1:0]  csr_data
);
   import fpfa_pkg::*;

   logic [SIZE_W-1:0] size_ff [MAX_PARTS];
   logic [MAX_PARTS-1:0] taken_ff;
   logic [CNT_W-1:0] count_ff;

   func_type          func_ff;
   logic [PIDX_W-1:0] pidx_ff;
   logic [SIZE_W-1:0] psize_ff;
   logic [SIZE_W-1:0] need_ff;
   logic [PID_W-1:0]  pid_ff;

   logic [IDX_W-1:0]  scan_idx_ff;
   logic              found_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic [SIZE_W-1:0] best_size_ff;

   logic              rsp_valid_ff;
   logic              granted_ff;
   logic [CNT_W-1:0]  number_ff;
   logic [PID_W-1:0]  pid_out_ff;

   logic [CNT_W-1:0]  live_count;
   logic [SIZE_W-1:0] cur_size;
   logic              fit;
   logic              take;
   logic              grant_now;
   logic              write_ok;

   assign live_count = (count_ff > CNT_W'(MAX_PARTS)) ? CNT_W'(MAX_PARTS) : count_ff;
   assign cur_size   = size_ff[scan_idx_ff];
   assign fit        = !taken_ff[scan_idx_ff] && (cur_size >= need_ff);
   assign take       = fit && (!found_ff ||
                       ((func_ff == FUNC_WORST) && (cur_size > best_size_ff)) ||
                       ((func_ff == FUNC_BEST) && (cur_size < best_size_ff)));
   assign grant_now  = found_ff && (func_ff != FUNC_WRITE);
   assign write_ok   = (func_ff == FUNC_WRITE) && (int'(pidx_ff) < MAX_PARTS);

   assign status.scan_skip = (func_ff == FUNC_WRITE) || (live_count == '0);
   assign status.scan_last = ({1'b0, scan_idx_ff} == (live_count - CNT_W'(1)));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid) begin
         count_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= func_type'(req_func);
         pidx_ff  <= req_part_index;
         psize_ff <= req_part_size;
         need_ff  <= req_request_size;
         pid_ff   <= req_process_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         found_ff    <= 1'b0;
      end else if (cmd.capture) begin
         scan_idx_ff <= '0;
         found_ff    <= 1'b0;
      end else if (cmd.scan_step) begin
         scan_idx_ff <= scan_idx_ff + IDX_W'(1);
         if (take) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step && take) begin
         best_idx_ff  <= scan_idx_ff;
         best_size_ff <= cur_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff <= '0;
         for (int i = 0; i < MAX_PARTS; i++) begin
            size_ff[i] <= '0;
         end
      end else if (cmd.finish) begin
         if (write_ok) begin
            size_ff[pidx_ff[IDX_W-1:0]]  <= psize_ff;
            taken_ff[pidx_ff[IDX_W-1:0]] <= 1'b0;
         end else if (grant_now) begin
            taken_ff[best_idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         granted_ff <= grant_now;
         number_ff  <= grant_now ? (CNT_W'(best_idx_ff) + CNT_W'(1)) : '0;
         pid_out_ff <= pid_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_granted          = granted_ff;
   assign rsp_partition_number = number_ff;
   assign rsp_process_id_out   = pid_out_ff;

   `FPFA_ASSERT_NOW(a_grant_has_number, clock, reset, rsp_valid_ff && granted_ff, number_ff != '0, "Granted item carries partition number zero.")
   `FPFA_ASSERT_NOW(a_refusal_no_number, clock, reset, rsp_valid_ff && !granted_ff, number_ff == '0, "Refused item carries a partition number.")
   `FPFA_ASSERT_NOW(a_scan_in_range, clock, reset, cmd.scan_step, CNT_W'(scan_idx_ff) < live_count, "Scan index passed the live partition count.")
   `FPFA_ASSERT_NEXT(a_grant_marks_taken, clock, reset, cmd.finish && grant_now && !write_ok, taken_ff[$past(best_idx_ff)], "Granted partition not marked taken.")

endmodule

// File: rtl/fpfa_controller.sv
// Control state machine of the allocator: accept, scan sequencing and result hand-off.
// Depends on fpfa_pkg.
module fpfa_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  fpfa_pkg::status_type status,
   output fpfa_pkg::cmd_type    cmd
);
   import fpfa_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_skip || status.scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd.capture   = 1'b0;
      cmd.scan_step = 1'b0;
      cmd.finish    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_SCAN: begin
            cmd.scan_step = !status.scan_skip;
         end
         ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// File: rtl/fixed_partition_fit_allocator.sv
// An accepted item passes a scan state, then a finish state that registers its result.
// The scan checks one entry per cycle over the partition count capped at the table depth;
// no entry is scanned for size writes or a count of zero. A new item is accepted only after
// the last one finishes; a result still held by the receiver when the next item ends its scan delays that item.
// Reset: synchronous, active high; clears the count, all sizes and all taken flags.
// Top level; depends on fpfa_pkg, fpfa_controller and fpfa_datapath.
module fixed_partition_fit_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [fpfa_pkg::FUNC_W-1:0] req_func,
   input  logic [fpfa_pkg::PIDX_W-1:0] req_part_index,
   input  logic [fpfa_pkg::SIZE_W-1:0] req_part_size,
   input  logic [fpfa_pkg::SIZE_W-1:0] req_request_size,
   input  logic [fpfa_pkg::PID_W-1:0]  req_process_id,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_granted,
   output logic [fpfa_pkg::CNT_W-1:0]  rsp_partition_number,
   output logic [fpfa_pkg::PID_W-1:0]  rsp_process_id_out,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [fpfa_pkg::CNT_W-1:0]  csr_data
);
   import fpfa_pkg::*;

   cmd_type    cmd;
   status_type status;

   fpfa_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fpfa_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_func             (req_func),
      .req_part_index       (req_part_index),
      .req_part_size        (req_part_size),
      .req_request_size     (req_request_size),
      .req_process_id       (req_process_id),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_granted          (rsp_granted),
      .rsp_partition_number (rsp_partition_number),
      .rsp_process_id_out   (rsp_process_id_out),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data)
   );

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the fixed partition fit allocator: a predictor
// tracks partition sizes, taken flags and the count, and checks every result.
// Depends on fpfa_pkg and the fixed_partition_fit_allocator top level.
module testbench;
   import fpfa_pkg::*;

   typedef struct {
      bit                 granted;
      logic [CNT_W-1:0]   number;
      logic [PID_W-1:0]   pid;
   } alloc_result_type;

   class partition_book;
      logic [SIZE_W-1:0] part_size[MAX_PARTS];
      bit                part_taken[MAX_PARTS];
      logic [CNT_W-1:0]  part_count;
      alloc_result_type  pending_results[$];
      int                mismatches;
      int                writes;
      int                grants;
      int                refusals;

      function new();
         foreach (part_size[i]) begin
            part_size[i]  = '0;
            part_taken[i] = 1'b0;
         end
         part_count = '0;
         mismatches = 0;
         writes     = 0;
         grants     = 0;
         refusals   = 0;
      endfunction

      function void set_count(logic [CNT_W-1:0] value);
         part_count = value;
      endfunction

      function void note_request(func_type func, logic [PIDX_W-1:0] index,
                                 logic [SIZE_W-1:0] size, logic [SIZE_W-1:0] need,
                                 logic [PID_W-1:0] pid);
         alloc_result_type  res;
         int                span;
         bit                found;
         int                pick;
         logic [SIZE_W-1:0] pick_size;
         res.granted = 1'b0;
         res.number  = '0;
         res.pid     = pid;
         if (func == FUNC_WRITE) begin
            part_size[index]  = size;
            part_taken[index] = 1'b0;
            writes++;
         end else begin
            span      = (part_count > MAX_PARTS) ? MAX_PARTS : int'(part_count);
            found     = 1'b0;
            pick      = 0;
            pick_size = '0;
            for (int i = 0; i < span; i++) begin
               if (part_taken[i] || part_size[i] < need) continue;
               if (!found) begin
                  found     = 1'b1;
                  pick      = i;
                  pick_size = part_size[i];
                  if (func == FUNC_FIRST) break;
               end else if (func == FUNC_WORST && part_size[i] > pick_size) begin
                  pick      = i;
                  pick_size = part_size[i];
               end else if (func == FUNC_BEST && part_size[i] < pick_size) begin
                  pick      = i;
                  pick_size = part_size[i];
               end
            end
            if (found) begin
               part_taken[pick] = 1'b1;
               res.granted      = 1'b1;
               res.number       = CNT_W'(pick + 1);
               grants++;
            end else begin
               refusals++;
            end
         end
         pending_results.push_back(res);
      endfunction

      function void check_result(bit granted, logic [CNT_W-1:0] number,
                                 logic [PID_W-1:0] pid);
         alloc_result_type exp_res;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: granted=%0d part=%0d pid=%h",
                        granted, number, pid);
            return;
         end
         exp_res = pending_results.pop_front();
         if (granted !== exp_res.granted || number !== exp_res.number ||
             pid !== exp_res.pid) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected granted=%0d part=%0d pid=%h, got granted=%0d part=%0d pid=%h",
                        exp_res.granted, exp_res.number, exp_res.pid, granted, number, pid);
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [FUNC_W-1:0] req_func;
   logic [PIDX_W-1:0] req_part_index;
   logic [SIZE_W-1:0] req_part_size;
   logic [SIZE_W-1:0] req_request_size;
   logic [PID_W-1:0]  req_process_id;
   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_granted;
   logic [CNT_W-1:0]  rsp_partition_number;
   logic [PID_W-1:0]  rsp_process_id_out;
   logic              csr_valid;
   logic              csr_ready;
   logic [CNT_W-1:0]  csr_data;

   partition_book book;
   int            req_gap_pct;
   int            rsp_stall_pct;
   bit            quiet;
   bit            long_hold_req;
   int            count_settings;

   fixed_partition_fit_allocator i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (req_func),
      .req_part_index       (req_part_index),
      .req_part_size        (req_part_size),
      .req_request_size     (req_request_size),
      .req_process_id       (req_process_id),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_granted          (rsp_granted),
      .rsp_partition_number (rsp_partition_number),
      .rsp_process_id_out   (rsp_process_id_out),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("timeout waiting on the allocator");
      $display("testbench: errors");
      $finish;
   end

   // The receiver decides its ready at falling edges; a long hold is counted here.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10) - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         book.check_result(rsp_granted, rsp_partition_number, rsp_process_id_out);
   end

   task automatic send_item(func_type func, logic [PIDX_W-1:0] index,
                            logic [SIZE_W-1:0] size, logic [SIZE_W-1:0] need,
                            logic [PID_W-1:0] pid);
      @(negedge clock);
      req_valid        <= 1'b1;
      req_func         <= func;
      req_part_index   <= index;
      req_part_size    <= size;
      req_request_size <= need;
      req_process_id   <= pid;
      do @(posedge clock); while (!req_ready);
      book.note_request(func, index, size, need, pid);
   endtask

   task automatic maybe_gap();
      if (!quiet && $urandom_range(0, 99) < req_gap_pct) begin
         repeat ($urandom_range(1, 10)) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (book.pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_count(logic [CNT_W-1:0] value);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      book.set_count(value);
      count_settings++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 9))
         0:       return SIZE_W'($urandom);
         1:       return '1;
         2:       return '0;
         default: return SIZE_W'($urandom_range(0, 1023));
      endcase
   endfunction

   task automatic send_random();
      int       sel;
      func_type func;
      sel = $urandom_range(0, 99);
      if (sel < 35)      func = FUNC_WRITE;
      else if (sel < 55) func = FUNC_FIRST;
      else if (sel < 78) func = FUNC_WORST;
      else               func = FUNC_BEST;
      send_item(func, PIDX_W'($urandom_range(0, 15)), pick_size(), pick_size(),
                PID_W'($urandom));
   endtask

   initial begin
      logic [CNT_W-1:0] phase_counts[10];
      book             = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_func         = FUNC_WRITE;
      req_part_index   = '0;
      req_part_size    = '0;
      req_request_size = '0;
      req_process_id   = '0;
      csr_valid        = 1'b0;
      csr_data         = '0;
      req_gap_pct      = 0;
      rsp_stall_pct    = 0;
      quiet            = 1'b0;
      long_hold_req    = 1'b0;
      count_settings   = 0;
      phase_counts     = '{5'd16, 5'd31, 5'd1, 5'd2, 5'd8, 5'd0, 5'd17, 5'd5, 5'd12, 5'd16};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // With the count still zero from reset, no request can be granted.
      send_item(FUNC_FIRST, 4'd0, 16'h0000, 16'h0000, 16'h0000);
      send_item(FUNC_WRITE, 4'd0, 16'd100, 16'hFFFF, 16'hFFFF);
      send_item(FUNC_WRITE, 4'd1, 16'd300, 16'h0000, 16'h0001);
      send_item(FUNC_WRITE, 4'd2, 16'd200, 16'h0000, 16'h0002);
      send_item(FUNC_WRITE, 4'd3, 16'd300, 16'h0000, 16'h0003);
      send_item(FUNC_WRITE, 4'd15, 16'hFFFF, 16'h0000, 16'h0004);
      send_item(FUNC_WRITE, 4'd4, 16'h0000, 16'hFFFF, 16'h0005);
      write_count(5'd4);
      send_item(FUNC_WORST, 4'd0, 16'h0000, 16'd150, 16'h1234);
      send_item(FUNC_BEST, 4'd0, 16'h0000, 16'd150, 16'h5678);
      send_item(FUNC_FIRST, 4'd0, 16'h0000, 16'h0000, 16'h9ABC);
      send_item(FUNC_FIRST, 4'd0, 16'h0000, 16'hFFFF, 16'hDEF0);
      send_item(FUNC_WRITE, 4'd1, 16'd300, 16'h0000, 16'h0006);
      send_item(FUNC_BEST, 4'hF, 16'hFFFF, 16'd301, 16'h0007);
      send_item(FUNC_WORST, 4'd0, 16'h0000, 16'h0000, 16'h0008);
      write_count(5'd31);
      send_item(FUNC_FIRST, 4'd0, 16'h0000, 16'hFFFF, 16'h0009);
      send_item(FUNC_WORST, 4'd0, 16'h0000, 16'h0000, 16'h000A);
      send_item(FUNC_BEST, 4'd0, 16'h0000, 16'h0000, 16'h000B);
      send_item(FUNC_BEST, 4'd0, 16'h0000, 16'h0000, 16'hFFFF);
      write_count(5'd16);
      send_item(FUNC_WORST, 4'd0, 16'h0000, 16'h0001, 16'h000C);

      for (int phase = 0; phase < 10; phase++) begin
         write_count(phase_counts[phase]);
         req_gap_pct   = (phase % 3 == 1) ? 0 : $urandom_range(5, 30);
         rsp_stall_pct = (phase % 4 == 2) ? 0 : $urandom_range(5, 30);
         quiet         = (phase == 9);
         for (int n = 0; n < 200; n++) begin
            if (phase == 2 && n == 20) long_hold_req = 1'b1;
            if (phase == 4 && n == 100) drain();
            send_random();
            maybe_gap();
         end
      end

      drain();
      repeat (40) @(posedge clock);
      $display("covered %0d size writes, %0d grants, %0d refusals over %0d count settings",
               book.writes, book.grants, book.refusals, count_settings);
      $display("%0d mismatches, %0d results still outstanding",
               book.mismatches, book.pending_results.size());
      if (book.mismatches == 0 && book.pending_results.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end
endmodule

// File: files.f
+incdir+rtl
rtl/fpfa_pkg.sv
rtl/fpfa_datapath.sv
rtl/fpfa_controller.sv
rtl/fixed_partition_fit_allocator.sv
bench/testbench.sv
